@@ hdl/isotp_pkg.sv @@
// Shared types and constants for the ISO-TP receive reassembler.
// No dependencies; imported by every module in hdl/.
package isotp_pkg;

  localparam int unsigned FrameBytes      = 7;   // payload bytes in one CAN frame
  localparam int unsigned FirstFrameBytes = 6;   // message bytes carried by a first frame
  localparam int unsigned QueueDepth      = 2;   // command queue between front and back
  localparam int unsigned QueuePtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW       = $clog2(QueueDepth + 1);

  localparam int unsigned PayloadW = 8 * FrameBytes;
  localparam int unsigned LenW     = 12;
  localparam int unsigned SeqW     = 4;
  localparam int unsigned CountW   = 3;          // holds 1..FrameBytes

  // PCI frame type, upper nibble of frame byte 0
  typedef enum logic [3:0] {
    PciSingle = 4'h0,
    PciFirst  = 4'h1,
    PciConsec = 4'h2
  } pci_type_e;

  typedef struct packed {
    logic [7:0]          pci_byte;
    logic [PayloadW-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [LenW-1:0] byte_index;
    logic            byte_valid;
    logic [SeqW-1:0] seq_number;
    logic            message_done;
    logic            sequence_error;
    logic [LenW-1:0] message_length;
    logic            last;
  } result_t;

  // One classified frame: the back end expands it into count results.
  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic [CountW-1:0]   count;      // results to emit, 1..7
    logic                offset;     // first message byte is frame byte 2 (first frame)
    logic [LenW-1:0]     base;       // message index of the first byte
    logic                has_bytes;  // results carry message bytes
    logic                done;       // final result completes the message
    logic                err;        // rejected consecutive frame
    logic [SeqW-1:0]     seq;        // held sequence number to report
  } cmd_t;

endpackage

@@ hdl/isotp_front.sv @@
// Front end: accepts frames, tracks reassembly state, issues commands.
// Depends on isotp_pkg.
module isotp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  isotp_pkg::frame_t     in_data_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output isotp_pkg::cmd_t       cmd_o
);
  import isotp_pkg::*;

  logic [LenW-1:0] rem_q, rem_d;
  logic [LenW-1:0] wc_q, wc_d;
  logic [SeqW-1:0] exp_q, exp_d;
  logic [SeqW-1:0] held_q, held_d;

  logic            accept;
  logic            emit;
  logic [3:0]      low;
  logic [7:0]      byte1;
  logic [LenW-1:0] total;
  pci_type_e       ptype;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && emit;

  assign low   = in_data_i.pci_byte[3:0];
  assign byte1 = in_data_i.payload[PayloadW-1 -: 8];
  assign total = {low, byte1};
  assign ptype = pci_type_e'(in_data_i.pci_byte[7:4]);

  always_comb begin
    rem_d  = rem_q;
    wc_d   = wc_q;
    exp_d  = exp_q;
    held_d = held_q;
    emit   = 1'b0;
    cmd_o           = '0;
    cmd_o.payload   = in_data_i.payload;
    cmd_o.seq       = held_q;
    cmd_o.count     = CountW'(1);
    case (ptype)
      PciSingle: begin
        if (low <= 4'(FrameBytes)) begin
          emit            = 1'b1;
          rem_d           = '0;
          wc_d            = LenW'(low);
          cmd_o.has_bytes = (low != 4'd0);
          cmd_o.count     = (low == 4'd0) ? CountW'(1) : low[CountW-1:0];
          cmd_o.done      = 1'b1;
        end
      end
      PciFirst: begin
        emit            = 1'b1;
        rem_d           = (total >= LenW'(FirstFrameBytes)) ?
                          total - LenW'(FirstFrameBytes) : '0;
        exp_d           = SeqW'(1);
        wc_d            = LenW'(FirstFrameBytes);
        cmd_o.has_bytes = 1'b1;
        cmd_o.count     = CountW'(FirstFrameBytes);
        cmd_o.offset    = 1'b1;
      end
      PciConsec: begin
        emit      = 1'b1;
        held_d    = low;
        cmd_o.seq = low;
        if (low != exp_q || rem_q == '0) begin
          rem_d     = '0;
          wc_d      = '0;
          cmd_o.err = 1'b1;
        end else begin
          exp_d           = exp_q + SeqW'(1);
          cmd_o.has_bytes = 1'b1;
          cmd_o.base      = wc_q;
          if (rem_q > LenW'(FrameBytes)) begin
            cmd_o.count = CountW'(FrameBytes);
            rem_d       = rem_q - LenW'(FrameBytes);
          end else begin
            cmd_o.count = rem_q[CountW-1:0];
            cmd_o.done  = 1'b1;
            rem_d       = '0;
          end
          wc_d = wc_q + LenW'(cmd_o.count);
        end
      end
      default: begin
        emit = 1'b0;  // other frame types are dropped
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      wc_q   <= '0;
      exp_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      rem_q  <= rem_d;
      wc_q   <= wc_d;
      exp_q  <= exp_d;
      held_q <= held_d;
    end
  end

  // a consecutive frame that delivers bytes never asks for more than remained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.has_bytes && !cmd_o.offset && cmd_o.base != '0
      |-> LenW'(cmd_o.count) <= rem_q)
    else $error("consecutive frame count exceeds remaining bytes");

endmodule

@@ hdl/isotp_queue.sv @@
// Short command queue that decouples the frame front end from the byte back end.
// Depends on isotp_pkg.
module isotp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  isotp_pkg::cmd_t  cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output isotp_pkg::cmd_t  head_o
);
  import isotp_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  function automatic logic [QueuePtrW-1:0] ptr_inc(logic [QueuePtrW-1:0] p);
    ptr_inc = (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue occupancy beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

@@ hdl/isotp_back.sv @@
// Back end: expands each command into indexed results, one per cycle
// unless stalled, into a registered output stage. Depends on isotp_pkg.
module isotp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  isotp_pkg::cmd_t       head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output isotp_pkg::result_t    out_data_o
);
  import isotp_pkg::*;

  logic [CountW-1:0]   k_q, k_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, res;
  logic                advance;
  logic                last;
  logic [CountW-1:0]   sel;
  logic [PayloadW-1:0] shifted;
  logic [LenW-1:0]     idx;

  assign advance = !out_valid_q || !out_stall_i;
  assign last    = (k_q == head_i.count - CountW'(1));
  assign sel     = k_q + CountW'(head_i.offset);
  assign shifted = head_i.payload >> {CountW'(FrameBytes - 1) - sel, 3'b000};
  assign idx     = head_i.base + LenW'(k_q);
  assign pop_o   = advance && head_valid_i && last;

  always_comb begin
    res                = '0;
    res.byte_valid     = head_i.has_bytes;
    res.seq_number     = head_i.seq;
    res.message_done   = head_i.done && last;
    res.sequence_error = head_i.err;
    res.last           = last;
    if (head_i.has_bytes) begin
      res.data_byte      = shifted[7:0];
      res.byte_index     = idx;
      res.message_length = idx + LenW'(1);
    end
    out_valid_d = out_valid_q;
    k_d         = k_q;
    if (advance) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        k_d = last ? '0 : k_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && head_valid_i) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sequence_error
      |-> !out_data_o.byte_valid && out_data_o.last)
    else $error("error result must be a lone byteless result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.message_done |-> out_data_o.last)
    else $error("message completion not on final result of frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> k_q < head_i.count)
    else $error("byte counter ran past command count");

endmodule

@@ hdl/isotp_frame_reassembler.sv @@
// Top level of the ISO-TP receive reassembler.
// Depends on isotp_pkg, isotp_front, isotp_queue and isotp_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one received CAN
//   frame per transaction: the PCI byte and the seven payload bytes.
//   Output channel (out_valid_o / out_stall_i / out_data_o) delivers one indexed
//   message byte, or one status-only result, per transaction.
//   Single frames give 0..7 bytes at index 0 and complete a message; an empty
//   single frame gives one byteless result marked done. First frames give six
//   bytes and arm the sequence check; consecutive frames give up to seven bytes
//   at running indices. A rejected consecutive frame gives one result with
//   sequence_error set. Frames of other types, and oversized single frames, are
//   taken and dropped without any result.
//   The first result of a frame is written into the command queue and then into
//   the output register, where it is held while the output is stalled.
//   Throughput: the front takes one frame per cycle while the two-entry command
//   queue has room; the back emits one result per cycle while the output is not
//   stalled, and each command gives 1 to 7 results.
//   Reset clears the reassembly state, the queue and the output valid flag.
//   A stall on the output holds the current result; the queue then fills and
//   in_stall_o rises, stalling the sender.
module isotp_frame_reassembler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  isotp_pkg::frame_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output isotp_pkg::result_t    out_data_o
);
  import isotp_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t cmd;
  cmd_t head;

  // Frame classification and reassembly state
  isotp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  // Decouples frame intake from byte output
  isotp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // Byte expansion and output register
  isotp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
